// ----- rtl/swds_pkg.sv -----
// ----------------------------------------------------------------------------
// swds_pkg
// Types, register codes and constants for the stepper wave-drive sequencer.
// ----------------------------------------------------------------------------
package swds_pkg;

  localparam int PERIOD_W  = 15;
  localparam int COUNT_W   = 15;
  localparam int DIV_W     = 16;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 15'd3000;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 15'd0;

  // register index, taken from paddr[2]
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    DIR_STOP  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_HOLD  = 2'd3
  } dir_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] step_period;
    logic [COUNT_W-1:0]  step_count;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    dir_t       direction;
    logic       host_busy;
  } item_t;

  typedef struct packed {
    logic       running;
    logic       done_event;
    logic [7:0] coil_port;
  } res_t;

  function automatic logic [7:0] coil_pattern(input logic [1:0] phase);
    logic [7:0] pat;
    case (phase)
      2'd0:    pat = 8'h10;
      2'd1:    pat = 8'h20;
      2'd2:    pat = 8'h40;
      default: pat = 8'h80;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/swds_regs.sv -----
// ----------------------------------------------------------------------------
// swds_regs
// Configuration register file behind the APB port.
// ----------------------------------------------------------------------------
module swds_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [swds_pkg::ADDR_W-1:0] paddr,
  input  logic [swds_pkg::DATA_W-1:0] pwdata,
  output logic [swds_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output swds_pkg::cfg_t             cfg
);
  import swds_pkg::*;

  logic [PERIOD_W-1:0] step_period;
  logic [COUNT_W-1:0]  step_count;
  logic                wr_en;
  logic                reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= PERIOD_RESET;
      step_count  <= COUNT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PERIOD: step_period <= pwdata[PERIOD_W-1:0];
        REG_COUNT:  step_count  <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PERIOD: prdata = {{(DATA_W-PERIOD_W){1'b0}}, step_period};
      REG_COUNT:  prdata = {{(DATA_W-COUNT_W){1'b0}}, step_count};
      default:    prdata = '0;
    endcase
  end

  assign cfg.step_period = step_period;
  assign cfg.step_count  = step_count;

endmodule

// ----- rtl/swds_core.sv -----
// ----------------------------------------------------------------------------
// swds_core
// Sequencer state and the per-item update: divider, phase, step count, event.
// ----------------------------------------------------------------------------
module swds_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           step_en,
  input  swds_pkg::item_t item,
  input  swds_pkg::cfg_t  cfg,
  output swds_pkg::res_t  res
);
  import swds_pkg::*;

  dir_t                run_direction;
  logic [DIV_W-1:0]    divider_count;
  logic [1:0]          phase_index;
  logic [COUNT_W-1:0]  steps_left;
  logic                done_pending;
  logic [7:0]          port_value;

  dir_t                run_direction_next;
  logic [DIV_W-1:0]    divider_count_next;
  logic [1:0]          phase_index_next;
  logic [COUNT_W-1:0]  steps_left_next;
  logic                done_pending_next;
  logic [7:0]          port_value_next;
  logic                sent;

  logic                running;
  logic                div_zero;
  logic [DIV_W-1:0]    div_dec;

  assign running  = (run_direction != DIR_STOP) && (steps_left != '0);
  assign div_zero = (divider_count == '0);
  assign div_dec  = (div_zero ? {1'b0, cfg.step_period} : divider_count) - 1'b1;

  always_comb begin
    run_direction_next = run_direction;
    divider_count_next = divider_count;
    phase_index_next   = phase_index;
    steps_left_next    = steps_left;
    done_pending_next  = done_pending;
    port_value_next    = port_value;
    sent               = 1'b0;
    if (item.cmd) begin
      steps_left_next    = cfg.step_count;
      run_direction_next = item.direction;
      done_pending_next  = 1'b1;
    end else if (running) begin
      if (run_direction == DIR_LEFT || run_direction == DIR_RIGHT) begin
        divider_count_next = div_dec;
        if (div_zero) begin
          phase_index_next = (run_direction == DIR_LEFT) ? phase_index - 2'd1
                                                         : phase_index + 2'd1;
          steps_left_next  = steps_left - 1'b1;
          port_value_next  = coil_pattern(phase_index_next);
        end
      end
    end else begin
      divider_count_next = div_dec;
      if (div_zero) begin
        port_value_next = 8'h00;
        if (done_pending) begin
          done_pending_next = 1'b0;
          sent              = !item.host_busy;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_direction <= DIR_STOP;
      divider_count <= '0;
      phase_index   <= '0;
      steps_left    <= '0;
      done_pending  <= 1'b0;
      port_value    <= '0;
    end else if (step_en) begin
      run_direction <= run_direction_next;
      divider_count <= divider_count_next;
      phase_index   <= phase_index_next;
      steps_left    <= steps_left_next;
      done_pending  <= done_pending_next;
      port_value    <= port_value_next;
    end
  end

  assign res.coil_port  = port_value_next;
  assign res.done_event = sent;
  assign res.running    = (run_direction_next != DIR_STOP) && (steps_left_next != '0);

`ifndef SYNTHESIS
  a_coil_onehot: assert property (@(posedge clk) disable iff (rst)
    port_value[3:0] == 4'h0 && $onehot0(port_value))
    else $error("coil pattern not one-hot");

  a_event_armed: assert property (@(posedge clk) disable iff (rst)
    step_en && sent |-> done_pending && !item.cmd)
    else $error("completion event without pending run");

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    step_en && item.cmd |=> done_pending && steps_left == $past(cfg.step_count))
    else $error("start item did not arm the run");

  a_step_used: assert property (@(posedge clk) disable iff (rst)
    step_en && !item.cmd && running && div_zero &&
    (run_direction == DIR_LEFT || run_direction == DIR_RIGHT)
    |=> steps_left == $past(steps_left) - 1'b1)
    else $error("step not counted at divider reload");
`endif

endmodule

// ----- rtl/stepper_wave_drive_sequencer.sv -----
// ----------------------------------------------------------------------------
// stepper_wave_drive_sequencer
// Four-phase full-step wave-drive sequencer with tick/start items and APB
// configuration.
// ----------------------------------------------------------------------------
// Result path: the input item is captured in the input register, then the state
//   update is registered into the result register.
// Throughput: one item per cycle while m_tready does not stall the output stage.
// Reset: synchronous, active high; clears state, both stages and restores
//   step_period to 3000 and step_count to 0.
module stepper_wave_drive_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [swds_pkg::IN_TDATA_W-1:0]  s_tdata,  // [1:0] direction, [2] host_busy
  input  logic                            s_tuser,  // [0] cmd
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [swds_pkg::OUT_TDATA_W-1:0] m_tdata,  // [7:0] coil_port, [8] done_event,
                                                     // [9] running
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swds_pkg::ADDR_W-1:0]      paddr,
  input  logic [swds_pkg::DATA_W-1:0]      pwdata,
  output logic [swds_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);
  import swds_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  logic  in_valid;
  res_t  core_res;
  res_t  out_res;
  logic  out_valid;
  logic  out_free;
  logic  adv;

  swds_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_free = !out_valid || m_tready;
  assign adv      = in_valid && out_free;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.cmd       <= s_tuser;
      in_item.direction <= dir_t'(s_tdata[1:0]);
      in_item.host_busy <= s_tdata[2];
    end
  end

  swds_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (adv),
    .item    (in_item),
    .cfg     (cfg),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_W-10){1'b0}}, out_res.running, out_res.done_event,
                     out_res.coil_port};

endmodule
